### hw/rtl/acpc_pkg.sv
package acpc_pkg;

	localparam int MaxNodes    = 1024;
	localparam int MaxPatterns = 64;
	localparam int Alphabet    = 26;
	localparam int CountBits   = 24;

	localparam logic [2:0] CMD_PATTERN = 3'd0;
	localparam logic [2:0] CMD_BUILD   = 3'd1;
	localparam logic [2:0] CMD_TEXT    = 3'd2;
	localparam logic [2:0] CMD_REPORT  = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NODES    = 2'd1;
	localparam logic [1:0] ST_PATTERNS = 2'd2;
	localparam logic [1:0] ST_PHASE    = 2'd3;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_PAT_RD,
		S_PAT_WR,
		S_TEXT_RD,
		S_TEXT_CNT,
		S_TEXT_WR,
		S_B_POP,
		S_B_POPW,
		S_B_RD,
		S_B_FRD,
		S_B_WR,
		S_R_POP,
		S_R_RDV,
		S_R_RDF,
		S_R_WR,
		S_P_END,
		S_P_CNT,
		S_P_OUT,
		S_Z_PASS,
		S_RESULT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_step;    // sweep one entry, advance clear index
		logic clear_start;
		logic pat_rd;        // read goto at cursor,symbol
		logic pat_wr;        // commit pattern symbol
		logic text_rd;
		logic text_cnt;
		logic text_wr;
		logic b_init;
		logic b_pop;
		logic b_popw;
		logic b_rd;
		logic b_frd;
		logic b_wr;
		logic r_init;
		logic r_pop;
		logic r_rdv;
		logic r_rdf;
		logic r_wr;
		logic p_init;
		logic p_end;
		logic p_cnt;
		logic p_next;
		logic z_init;
		logic z_step;
		logic set_built;
		logic latch_in;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic built;
		logic cursor_root;
		logic pat_full;
		logic node_full;
		logic goto_zero;
		logic sym_bad;
		logic b_done;
		logic b_sym_last;
		logic r_done;
		logic p_last;
		logic no_pat;
		logic z_done;
	} stat_t;

endpackage

### hw/rtl/aho_corasick_pattern_counter_top.sv
// Aho-Corasick pattern counter. Commands arrive as items on the input channel
// (pattern symbol, build, text symbol, report, clear) and one item is worked
// on at a time. After reset, and after a clear command, a clearing pass walks
// the goto memory before the next item is taken. A pattern symbol steps
// through S_PAT_RD and S_PAT_WR, a text symbol through S_TEXT_RD, S_TEXT_CNT
// and S_TEXT_WR, set by the registered goto and counter memory reads. Build
// pops each node (S_B_POP, S_B_POPW), then its letters (S_B_RD, S_B_FRD,
// S_B_WR) in breadth-first order; report sums the failure tree per node, gives
// each pattern result, then zeroes the counters in S_Z_PASS. An item that
// gives a result holds the input until its final result has been taken.
// Results leave through a registered output stage.
module aho_corasick_pattern_counter_top
	import acpc_pkg::*;
#(
	parameter int MAX_NODES    = MaxNodes,
	parameter int MAX_PATTERNS = MaxPatterns,
	parameter int ALPHABET     = Alphabet,
	parameter int COUNT_BITS   = CountBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [4:0]  symbol,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  pattern_index,
	output logic [23:0] count,
	output logic        last_res,
	output logic [1:0]  status
);
	cmd_t        c;
	stat_t       st;
	logic [5:0]  r_index;
	logic [23:0] r_count;

	// datapath: goto, failure, order, counter and pattern-end memories
	acpc_datapath #(
		.MAX_NODES(MAX_NODES), .MAX_PATTERNS(MAX_PATTERNS),
		.ALPHABET(ALPHABET), .COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .c(c), .symbol(symbol), .st(st),
		.r_index(r_index), .r_count(r_count)
	);

	// sequencer and output register
	acpc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .last(last), .st(st), .r_index(r_index), .r_count(r_count),
		.c(c), .out_valid(out_valid), .out_stall(out_stall),
		.pattern_index(pattern_index), .count(count), .last_res(last_res),
		.status(status)
	);

endmodule

### hw/rtl/acpc_datapath.sv
module acpc_datapath
	import acpc_pkg::*;
#(
	parameter int MAX_NODES    = MaxNodes,
	parameter int MAX_PATTERNS = MaxPatterns,
	parameter int ALPHABET     = Alphabet,
	parameter int COUNT_BITS   = CountBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        c,
	input  logic [4:0]  symbol,
	output stat_t       st,
	output logic [5:0]  r_index,
	output logic [23:0] r_count
);
	localparam int NB = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int SB = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int PB = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
	localparam int GD = MAX_NODES * ALPHABET;
	localparam int GB = $clog2(GD);
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	logic [NB-1:0]         goto_mem [GD];
	logic [NB-1:0]         fail_mem [MAX_NODES];
	logic [NB-1:0]         bfs_mem  [MAX_NODES];
	logic [COUNT_BITS-1:0] cnt_mem  [MAX_NODES];
	logic [NB-1:0]         end_mem  [MAX_PATTERNS];

	logic [GB:0]   clr_q;
	logic [NB:0]   node_total_q;
	logic [PB:0]   pat_total_q;
	logic [NB-1:0] cursor_q;
	logic          built_q;
	logic [SB-1:0] sym_q;
	logic          sym_bad_q;
	logic [NB:0]   head_q, tail_q;
	logic [NB-1:0] u_q, fu_q, v_q, f_q;
	logic [NB-1:0] g_rd_q, bfs_rd_q, fail_rd_q, end_rd_q;
	logic [COUNT_BITS-1:0] cnt_rd_q, cv_q;
	logic [PB:0]   p_q;
	logic [NB:0]   z_q;

	// shared memory address muxing
	logic [GB-1:0] g_addr;
	logic          g_we;
	logic [NB-1:0] g_wd;
	logic [NB-1:0] cnt_addr;
	logic          cnt_we;
	logic [COUNT_BITS-1:0] cnt_wd;
	logic [COUNT_BITS:0]   sum;
	logic sym_ok;

	function automatic logic [GB-1:0] gaddr(input logic [NB-1:0] n, input logic [SB-1:0] s);
		logic [GB+NB:0] t;
		t = GB'(n) * (GB+NB+1)'(ALPHABET) + (GB+NB+1)'(s);
		return t[GB-1:0];
	endfunction

	assign sum = {1'b0, cv_q} + {1'b0, cnt_rd_q};
	assign sym_ok = ({27'd0, symbol} < 32'(ALPHABET));

	always_comb begin
		g_addr = gaddr(cursor_q, sym_q);
		g_we = 1'b0;
		g_wd = '0;
		if (c.clear_step) begin
			g_addr = clr_q[GB-1:0];
			g_we = (clr_q < (GB+1)'(GD));
		end else if (c.pat_wr) begin
			g_we = st.goto_zero;
			g_wd = node_total_q[NB-1:0];
		end else if (c.b_rd) begin
			g_addr = gaddr(u_q, sym_q);
		end else if (c.b_frd) begin
			g_addr = gaddr(fu_q, sym_q);
		end else if (c.b_wr) begin
			g_addr = gaddr(u_q, sym_q);
			g_we = (v_q == '0);
			g_wd = g_rd_q;
		end
	end

	always_comb begin
		cnt_addr = g_rd_q;
		cnt_we = 1'b0;
		cnt_wd = '0;
		if (c.clear_step) begin
			cnt_addr = clr_q[NB-1:0];
			cnt_we = (clr_q < (GB+1)'(MAX_NODES));
		end else if (c.z_step) begin
			cnt_addr = z_q[NB-1:0];
			cnt_we = 1'b1;
		end else if (c.text_wr) begin
			cnt_addr = cursor_q;
			cnt_we = 1'b1;
			cnt_wd = (cnt_rd_q == CMAX) ? CMAX : cnt_rd_q + 1'b1;
		end else if (c.r_rdv) begin
			cnt_addr = bfs_rd_q;
		end else if (c.r_rdf) begin
			cnt_addr = fail_rd_q;
		end else if (c.r_wr) begin
			cnt_addr = f_q;
			cnt_we = 1'b1;
			cnt_wd = sum[COUNT_BITS] ? CMAX : sum[COUNT_BITS-1:0];
		end else if (c.p_cnt) begin
			cnt_addr = end_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (g_we) goto_mem[g_addr] <= g_wd;
		g_rd_q <= goto_mem[g_addr];
		if (cnt_we) cnt_mem[cnt_addr] <= cnt_wd;
		cnt_rd_q <= cnt_mem[cnt_addr];
		if (c.clear_step && clr_q < (GB+1)'(MAX_NODES)) fail_mem[clr_q[NB-1:0]] <= '0;
		else if (c.b_wr && v_q != '0)
			fail_mem[v_q] <= (u_q != '0) ? g_rd_q : '0;
		fail_rd_q <= fail_mem[(c.b_popw || c.r_rdv) ? bfs_rd_q : v_q];
		if (c.b_init) bfs_mem[0] <= '0;
		else if (c.b_wr && v_q != '0 && tail_q < (NB+1)'(MAX_NODES))
			bfs_mem[tail_q[NB-1:0]] <= v_q;
		bfs_rd_q <= bfs_mem[c.r_pop ? NB'(head_q - 1'b1) : head_q[NB-1:0]];
		if (c.pat_wr && c.latch_in) end_mem[pat_total_q[PB-1:0]] <= st.goto_zero ?
			node_total_q[NB-1:0] : g_rd_q;
		end_rd_q <= end_mem[p_q[PB-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			node_total_q <= (NB+1)'(1);
			pat_total_q <= '0;
			cursor_q <= '0;
			built_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			p_q <= '0;
			z_q <= '0;
		end else begin
			if (c.clear_start) begin
				clr_q <= '0;
				node_total_q <= (NB+1)'(1);
				pat_total_q <= '0;
				cursor_q <= '0;
				built_q <= 1'b0;
			end else if (c.clear_step) clr_q <= clr_q + 1'b1;
			if (c.pat_wr) begin
				if (st.goto_zero) node_total_q <= node_total_q + 1'b1;
				if (c.latch_in) begin
					cursor_q <= '0;
					pat_total_q <= pat_total_q + 1'b1;
				end else cursor_q <= st.goto_zero ? node_total_q[NB-1:0] : g_rd_q;
			end
			if (c.text_cnt) cursor_q <= g_rd_q;
			if (c.set_built) built_q <= 1'b1;
			if (c.b_init) begin
				head_q <= '0;
				tail_q <= (NB+1)'(1);
			end
			if (c.b_pop) head_q <= head_q + 1'b1;
			if (c.b_wr && v_q != '0 && tail_q < (NB+1)'(MAX_NODES)) tail_q <= tail_q + 1'b1;
			if (c.r_init) head_q <= node_total_q;
			if (c.r_pop) head_q <= head_q - 1'b1;
			if (c.p_init) p_q <= '0;
			if (c.p_next) p_q <= p_q + 1'b1;
			if (c.z_init) z_q <= '0;
			if (c.z_step) z_q <= z_q + 1'b1;
		end
	end

	// payload registers for walk state
	always_ff @(posedge clk) begin
		if (c.latch_in) begin
			sym_q <= SB'(symbol);
			sym_bad_q <= !sym_ok;
		end else if (c.b_popw) sym_q <= '0;
		else if (c.b_wr) sym_q <= sym_q + 1'b1;
		if (c.b_popw) u_q <= bfs_rd_q;
		if (c.b_frd) v_q <= g_rd_q;
		else if (c.r_rdv) v_q <= bfs_rd_q;
		if (c.r_rdf) begin
			f_q <= fail_rd_q;
			cv_q <= cnt_rd_q;
		end
	end

	// fail link of the popped node, taken on its first letter
	always_ff @(posedge clk) begin
		if (c.b_rd && sym_q == '0) fu_q <= fail_rd_q;
	end

	assign st.clear_done  = (clr_q >= (GB+1)'(GD));
	assign st.built       = built_q;
	assign st.cursor_root = (cursor_q == '0);
	assign st.pat_full    = (pat_total_q >= (PB+1)'(MAX_PATTERNS));
	assign st.node_full   = (node_total_q >= (NB+1)'(MAX_NODES));
	assign st.goto_zero   = (g_rd_q == '0);
	assign st.sym_bad     = sym_bad_q;
	assign st.b_done      = (head_q >= tail_q) || (head_q >= (NB+1)'(MAX_NODES));
	assign st.b_sym_last  = (sym_q == SB'(ALPHABET - 1));
	assign st.r_done      = (head_q <= (NB+1)'(1));
	assign st.p_last      = (p_q + 1'b1 == pat_total_q);
	assign st.no_pat      = (pat_total_q == '0);
	assign st.z_done      = (z_q >= (NB+1)'(MAX_NODES));
	assign r_index        = c.pat_wr ? 6'(pat_total_q) : 6'(p_q);
	assign r_count        = 24'(cnt_rd_q);

endmodule

### hw/rtl/acpc_ctrl.sv
module acpc_ctrl
	import acpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic        last,
	input  stat_t       st,
	input  logic [5:0]  r_index,
	input  logic [23:0] r_count,
	output cmd_t        c,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  pattern_index,
	output logic [23:0] count,
	output logic        last_res,
	output logic [1:0]  status
);
	state_t state_q, state_d;
	logic   last_q;
	logic   ov_q;
	logic   ld;
	logic [5:0]  oi_d;
	logic [23:0] oc_d;
	logic        ol_d;
	logic [1:0]  os_d;
	logic        idle_take;

	assign in_stall  = (state_q != S_IDLE);
	assign idle_take = (state_q == S_IDLE) && in_valid;
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		c = '0;
		ld = 1'b0;
		oi_d = '0;
		oc_d = '0;
		ol_d = 1'b1;
		os_d = ST_OK;
		unique case (state_q)
			S_CLEAR: begin
				c.clear_step = 1'b1;
				if (st.clear_done) state_d = S_RESULT;
			end
			S_IDLE: begin
				if (in_valid) begin
					c.latch_in = 1'b1;
					unique case (cmd)
						CMD_PATTERN: state_d = S_PAT_RD;
						CMD_BUILD: begin
							if (st.built || !st.cursor_root) begin
								ld = 1'b1; os_d = ST_PHASE; state_d = S_RESULT;
							end else begin
								c.b_init = 1'b1; state_d = S_B_POP;
							end
						end
						CMD_TEXT: state_d = S_TEXT_RD;
						CMD_REPORT: begin
							if (!st.built) begin
								ld = 1'b1; os_d = ST_PHASE; state_d = S_RESULT;
							end else begin
								c.r_init = 1'b1; state_d = S_R_POP;
							end
						end
						CMD_CLEAR: begin
							c.clear_start = 1'b1;
							ld = 1'b1;
							state_d = S_CLEAR;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_PAT_RD: begin
				if (st.built || st.sym_bad) begin
					ld = 1'b1; os_d = ST_PHASE; state_d = S_RESULT;
				end else if (st.pat_full) begin
					ld = 1'b1; os_d = ST_PATTERNS; state_d = S_RESULT;
				end else begin
					c.pat_rd = 1'b1; state_d = S_PAT_WR;
				end
			end
			S_PAT_WR: begin
				if (st.goto_zero && st.node_full) begin
					ld = 1'b1; os_d = ST_NODES; state_d = S_RESULT;
				end else begin
					c.pat_wr = 1'b1;
					c.latch_in = last_q;
					if (last_q) begin
						ld = 1'b1; oi_d = r_index; state_d = S_RESULT;
					end else state_d = S_IDLE;
				end
			end
			S_TEXT_RD: begin
				if (!st.built || st.sym_bad) begin
					ld = 1'b1; os_d = ST_PHASE; state_d = S_RESULT;
				end else state_d = S_TEXT_CNT;
			end
			S_TEXT_CNT: begin c.text_cnt = 1'b1; state_d = S_TEXT_WR; end
			S_TEXT_WR:  begin c.text_wr = 1'b1; state_d = S_IDLE; end
			S_B_POP: begin
				if (st.b_done) begin
					c.set_built = 1'b1; ld = 1'b1; state_d = S_RESULT;
				end else begin
					c.b_pop = 1'b1; state_d = S_B_POPW;
				end
			end
			S_B_POPW: begin c.b_popw = 1'b1; state_d = S_B_RD; end
			S_B_RD:   begin c.b_rd = 1'b1; state_d = S_B_FRD; end
			S_B_FRD:  begin c.b_frd = 1'b1; state_d = S_B_WR; end
			S_B_WR: begin
				c.b_wr = 1'b1;
				state_d = st.b_sym_last ? S_B_POP : S_B_RD;
			end
			S_R_POP: begin
				if (st.r_done) begin
					c.p_init = 1'b1; state_d = S_P_END;
				end else begin
					c.r_pop = 1'b1; state_d = S_R_RDV;
				end
			end
			S_R_RDV: begin c.r_rdv = 1'b1; state_d = S_R_RDF; end
			S_R_RDF: begin c.r_rdf = 1'b1; state_d = S_R_WR; end
			S_R_WR:  begin c.r_wr = 1'b1; state_d = S_R_POP; end
			S_P_END: begin
				if (st.no_pat) begin
					c.z_init = 1'b1; ld = 1'b1; state_d = S_Z_PASS;
				end else begin
					c.p_end = 1'b1; state_d = S_P_CNT;
				end
			end
			S_P_CNT: begin c.p_cnt = 1'b1; state_d = S_P_OUT; end
			S_P_OUT: begin
				c.p_cnt = 1'b1;
				if (!ov_q || !out_stall) begin
					ld = 1'b1; oi_d = r_index; oc_d = r_count; ol_d = st.p_last;
					if (st.p_last) begin
						c.z_init = 1'b1; state_d = S_Z_PASS;
					end else begin
						c.p_next = 1'b1; state_d = S_P_END;
					end
				end
			end
			S_Z_PASS: begin
				c.z_step = 1'b1;
				if (st.z_done) state_d = S_RESULT;
			end
			S_RESULT: if (!ov_q) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (ld && !(state_q == S_CLEAR)) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (idle_take) last_q <= last;
		if (ld) begin
			pattern_index <= oi_d;
			count <= oc_d;
			last_res <= ol_d;
			status <= os_d;
		end
	end

`ifndef ASSERT_OFF
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("item taken while busy");
	a_ld_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && state_q == S_P_OUT) |-> (!ov_q || !out_stall)) else $error("result overwritten");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
`endif

endmodule
